// ===== rtl/blr_pkg.sv =====
`timescale 1ns / 1ps

package blr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int POS_BITS    = COORD_BITS + 1;
  localparam int STR_BITS    = COORD_BITS + 2;
  localparam int DIAG_BITS   = COORD_BITS + 3;
  localparam int ERR_BITS    = COORD_BITS + 4;
  localparam int SIDE_BITS   = 8;
  localparam int INC_BITS    = 8;
  localparam int COLOUR_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  localparam int IN_DATA_BITS  = 4 * COORD_BITS + COLOUR_BITS;
  localparam int IN_TDATA_BITS = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 2 * COORD_BITS + 2 * SIDE_BITS + COLOUR_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BLOCK_SIDE = 1'b0,
    CFG_STEP_INC   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                    op;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    logic [COLOUR_BITS-1:0] colour;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  block_x;
    logic [COORD_BITS-1:0]  block_y;
    logic [SIDE_BITS-1:0]   block_width;
    logic [SIDE_BITS-1:0]   block_height;
    logic [COLOUR_BITS-1:0] block_colour;
    logic                   last_block;
  } result_t;

endpackage

// ===== rtl/blr_in_reg.sv =====
`timescale 1ns / 1ps

module blr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  blr_pkg::item_t  item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output blr_pkg::item_t  item_o
);
  import blr_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/blr_stepper.sv =====
`timescale 1ns / 1ps

module blr_stepper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [blr_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  blr_pkg::item_t                    item_i,
  input  logic                              adv_i,
  output logic                              res_valid_o,
  output blr_pkg::result_t                  res_o
);
  import blr_pkg::*;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  // Saturate at the all-ones position.
  function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                  input logic [INC_BITS-1:0] b);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + (POS_BITS + 1)'(b);
    sat_add = s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  function automatic logic [SIDE_BITS-1:0] clip_len(input logic [POS_BITS-1:0]   pos,
                                                    input logic [COORD_BITS-1:0] tgt,
                                                    input logic [SIDE_BITS-1:0]  side);
    logic [POS_BITS-1:0] room;
    room = (POS_BITS'(tgt) > pos) ? POS_BITS'(tgt) - pos : '0;
    clip_len = (room < POS_BITS'(side)) ? room[SIDE_BITS-1:0] : side;
  endfunction

  logic [SIDE_BITS-1:0]   side_q;
  logic [INC_BITS-1:0]    inc_q;
  logic [POS_BITS-1:0]    pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0]  tgt_x_q, tgt_y_q;
  logic signed [ERR_BITS-1:0]  err_q;
  logic [STR_BITS-1:0]         str_q;
  logic signed [DIAG_BITS-1:0] diag_q;
  logic                   x_major_q;
  logic                   active_q;
  logic [COLOUR_BITS-1:0] colour_q;

  // load path
  logic [COORD_BITS-1:0]       dx, dy, minor_d, major_d;
  logic                        ld_x_major;
  logic signed [ERR_BITS-1:0]  ld_err;
  logic [STR_BITS-1:0]         ld_str;
  logic signed [DIAG_BITS-1:0] ld_diag;
  logic [POS_BITS-1:0]         ld_pos_x, ld_pos_y;
  logic                        ld_active;

  // step path
  logic                        move_minor;
  logic signed [ERR_BITS-1:0]  st_err;
  logic [POS_BITS-1:0]         st_pos_x, st_pos_y;
  logic                        st_cond;
  logic                        st_last;

  always_comb begin
    dx         = abs_diff(item_i.end_x, item_i.start_x);
    dy         = abs_diff(item_i.end_y, item_i.start_y);
    ld_x_major = dy < dx;
    minor_d    = ld_x_major ? dy : dx;
    major_d    = ld_x_major ? dx : dy;
    ld_err     = ERR_BITS'({minor_d, 1'b0}) - ERR_BITS'(major_d);
    ld_str     = STR_BITS'({minor_d, 1'b0});
    ld_diag    = DIAG_BITS'({minor_d, 1'b0}) - DIAG_BITS'({major_d, 1'b0});
    ld_pos_x   = POS_BITS'(item_i.start_x);
    ld_pos_y   = POS_BITS'(item_i.start_y);
    ld_active  = ld_x_major ? (ld_pos_x < POS_BITS'(item_i.end_x))
                            : (ld_pos_y < POS_BITS'(item_i.end_y));
  end

  always_comb begin
    move_minor = !err_q[ERR_BITS-1];
    st_err     = move_minor ? err_q + ERR_BITS'(diag_q) : err_q + ERR_BITS'(str_q);
    st_pos_x   = (x_major_q || move_minor) ? sat_add(pos_x_q, inc_q) : pos_x_q;
    st_pos_y   = (!x_major_q || move_minor) ? sat_add(pos_y_q, inc_q) : pos_y_q;
    st_cond    = x_major_q ? (st_pos_x < POS_BITS'(tgt_x_q))
                           : (st_pos_y < POS_BITS'(tgt_y_q));
    st_last    = (inc_q == '0) || !st_cond;
  end

  assign res_valid_o        = (item_i.op == OP_STEP) && active_q;
  assign res_o.block_x      = pos_x_q[COORD_BITS-1:0];
  assign res_o.block_y      = pos_y_q[COORD_BITS-1:0];
  assign res_o.block_width  = clip_len(pos_x_q, tgt_x_q, side_q);
  assign res_o.block_height = clip_len(pos_y_q, tgt_y_q, side_q);
  assign res_o.block_colour = colour_q;
  assign res_o.last_block   = st_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_BITS'(1);
      inc_q  <= INC_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLOCK_SIDE: side_q <= cfg_data_i[SIDE_BITS-1:0];
        CFG_STEP_INC:   inc_q  <= cfg_data_i[INC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      err_q     <= '0;
      str_q     <= '0;
      diag_q    <= '0;
      x_major_q <= 1'b0;
      active_q  <= 1'b0;
      colour_q  <= '0;
    end else if (adv_i) begin
      if (item_i.op == OP_LOAD) begin
        pos_x_q   <= ld_pos_x;
        pos_y_q   <= ld_pos_y;
        tgt_x_q   <= item_i.end_x;
        tgt_y_q   <= item_i.end_y;
        err_q     <= ld_err;
        str_q     <= ld_str;
        diag_q    <= ld_diag;
        x_major_q <= ld_x_major;
        active_q  <= ld_active;
        colour_q  <= item_i.colour;
      end else if (active_q) begin
        pos_x_q  <= st_pos_x;
        pos_y_q  <= st_pos_y;
        err_q    <= st_err;
        active_q <= !st_last;
      end
    end
  end

endmodule

// ===== rtl/blr_out_reg.sv =====
`timescale 1ns / 1ps

module blr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  blr_pkg::result_t  res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              take_i,
  output blr_pkg::result_t  res_o
);
  import blr_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/block_line_rasterizer.sv =====
`timescale 1ns / 1ps

// Bresenham line stepper that emits square blocks. Send a load transaction
// (tuser = 0) with start, end and colour, then one step transaction
// (tuser = 1) per block; each step of an active line returns one block with
// its origin, clipped width and height, colour, and tlast on the final block.
// Loads and steps on an idle line return nothing. Positions only increase.
// One transaction is taken per cycle while the output side does not stall;
// a step is held in the input register, and the stepper update writes its
// result into the output register, which presents it on the master side.
// The rate is set by the stepper update of the position and error registers.
// Write block_side and step_increment only while no line is in flight.

module block_line_rasterizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [blr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_x, start_y, end_x, end_y, paint_colour
  input  logic [blr_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  // operation
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // block_x, block_y, block_width, block_height, block_colour
  output logic [blr_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import blr_pkg::*;

  item_t   s_item, in_item;
  logic    in_valid, adv;
  logic    res_valid, out_ready;
  result_t res, out_res;

  assign s_item.op      = op_e'(s_axis_tuser_i);
  assign s_item.start_x = s_axis_tdata_i[COORD_BITS-1:0];
  assign s_item.start_y = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign s_item.end_x   = s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
  assign s_item.end_y   = s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
  assign s_item.colour  = s_axis_tdata_i[4*COORD_BITS+COLOUR_BITS-1:4*COORD_BITS];

  // Items that yield no block never wait on the output side.
  assign adv = in_valid && (!res_valid || out_ready);

  blr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (s_item),
    .valid_o (in_valid),
    .pop_i   (adv),
    .item_o  (in_item)
  );

  blr_stepper u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_item),
    .adv_i       (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  blr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = OUT_TDATA_BITS'({out_res.block_colour, out_res.block_height,
                                           out_res.block_width, out_res.block_y,
                                           out_res.block_x});
  assign m_axis_tlast_o = out_res.last_block;

endmodule

// ===== test/tb_block_line_rasterizer.sv =====
`timescale 1ns / 1ps

module tb_block_line_rasterizer;
  import blr_pkg::*;

  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int POS_MAX      = (1 << POS_BITS) - 1;
  localparam int STALL_LIMIT  = 1500;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE_CYCLES = 6;
  localparam int PRINT_CAP    = 40;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  // start_x, start_y, end_x, end_y, paint_colour
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i;
  // operation
  logic                      s_axis_tuser_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  // block_x, block_y, block_width, block_height, block_colour
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic                      m_axis_tlast_o;

  block_line_rasterizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Line stepper mirror: registers, latched line and decision terms
  logic [SIDE_BITS-1:0]         side_reg = 8'd1;
  logic [INC_BITS-1:0]          inc_reg  = 8'd1;
  logic [POS_BITS-1:0]          cur_x = '0, cur_y = '0;
  logic [COORD_BITS-1:0]        goal_x = '0, goal_y = '0;
  logic signed [ERR_BITS-1:0]   decision = '0;
  logic [STR_BITS-1:0]          step_straight = '0;
  logic signed [DIAG_BITS-1:0]  step_diag = '0;
  logic                         along_x = 1'b0;
  logic                         drawing = 1'b0;
  logic [COLOUR_BITS-1:0]       ink = '0;

  result_t pending_blocks[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      src_idle_pct = 34;
  int      sink_idle_pct = 34;
  bit      sink_hold_req = 1'b0;

  function automatic int sat_pos(int a, int b);
    return (a + b > POS_MAX) ? POS_MAX : a + b;
  endfunction

  function automatic int clip_extent(int pos, int target, int side);
    int room;
    room = (target > pos) ? target - pos : 0;
    return (room < side) ? room : side;
  endfunction

  function automatic logic line_continues();
    return along_x ? (cur_x < goal_x) : (cur_y < goal_y);
  endfunction

  function automatic logic [IN_TDATA_BITS-1:0] line_word(
    logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
    logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey,
    logic [COLOUR_BITS-1:0] colour);
    return {colour, ey, ex, sy, sx};
  endfunction

  task automatic trace_line_item(op_e op, logic [IN_TDATA_BITS-1:0] payload);
    logic [COORD_BITS-1:0]  sx, sy, ex, ey;
    logic [COLOUR_BITS-1:0] colour;
    int      dx, dy, minor, major;
    logic    done;
    result_t blk;
    {colour, ey, ex, sy, sx} = payload[4*COORD_BITS+COLOUR_BITS-1:0];
    if (op == OP_LOAD) begin
      goal_x = ex;
      goal_y = ey;
      ink    = colour;
      dx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
      dy = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
      cur_x = POS_BITS'(sx);
      cur_y = POS_BITS'(sy);
      along_x = dy < dx;
      minor = along_x ? dy : dx;
      major = along_x ? dx : dy;
      decision      = ERR_BITS'(2 * minor - major);
      step_straight = STR_BITS'(2 * minor);
      step_diag     = DIAG_BITS'(2 * (minor - major));
      drawing = line_continues();
    end else if (drawing) begin
      blk.block_x      = cur_x[COORD_BITS-1:0];
      blk.block_y      = cur_y[COORD_BITS-1:0];
      blk.block_width  = SIDE_BITS'(clip_extent(int'(cur_x), int'(goal_x), int'(side_reg)));
      blk.block_height = SIDE_BITS'(clip_extent(int'(cur_y), int'(goal_y), int'(side_reg)));
      blk.block_colour = ink;
      if (decision < 0) begin
        decision = ERR_BITS'(int'(decision) + int'(step_straight));
      end else begin
        decision = ERR_BITS'(int'(decision) + int'(step_diag));
        if (along_x) cur_y = POS_BITS'(sat_pos(int'(cur_y), int'(inc_reg)));
        else cur_x = POS_BITS'(sat_pos(int'(cur_x), int'(inc_reg)));
      end
      if (along_x) cur_x = POS_BITS'(sat_pos(int'(cur_x), int'(inc_reg)));
      else cur_y = POS_BITS'(sat_pos(int'(cur_y), int'(inc_reg)));
      done = (inc_reg == '0) || !line_continues();
      drawing = !done;
      blk.last_block = done;
      pending_blocks.push_back(blk);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Called at a rising edge; returns at the edge that takes the transaction.
  task automatic send_item(op_e op, logic [IN_TDATA_BITS-1:0] payload);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= payload;
    @(negedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(negedge clk_i);
    trace_line_item(op, payload);
    @(posedge clk_i);
  endtask

  // Wait out every expected block plus the pipeline, so nothing is in flight.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [7:0] side, logic [7:0] inc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BLOCK_SIDE;
    cfg_data_i <= side;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STEP_INC;
    cfg_data_i <= inc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_reg = side;
    inc_reg  = inc;
  endtask

  task automatic test_idle_line_cases();
    program_regs(8'd1, 8'd1);
    // step with no line loaded
    send_item(OP_STEP, line_word(12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'hffff_ffff));
    // both deltas zero: line is dead on load
    send_item(OP_LOAD, line_word(12'd0, 12'd0, 12'd0, 12'd0, 32'h0));
    send_item(OP_STEP, line_word(12'd0, 12'd0, 12'd0, 12'd0, 32'h0));
    // major axis runs toward smaller values: nothing painted
    send_item(OP_LOAD, line_word(12'd0, COORD_BITS'(COORD_MAX), 12'd0, 12'd0,
                                 32'h1234_5678));
    send_item(OP_STEP, '0);
  endtask

  task automatic test_clipping_corners();
    drain();
    // zero side: x-major line with empty blocks
    program_regs(8'd0, 8'd3);
    send_item(OP_LOAD, line_word(12'd10, 12'd20, COORD_BITS'(COORD_MAX), 12'd25,
                                 32'h8040_2010));
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '0);
    drain();
    // zero increment: one block, then the line is over
    program_regs(8'd7, 8'd0);
    send_item(OP_LOAD, line_word(12'd5, 12'd5, 12'd100, 12'd50, 32'hdead_beef));
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '0);
  endtask

  task automatic test_canvas_overflow();
    drain();
    // minor axis climbs past the canvas edge with the widest steps
    program_regs(8'd255, 8'd255);
    send_item(OP_LOAD, line_word(COORD_BITS'(COORD_MAX), 12'd0, 12'd0,
                                 COORD_BITS'(COORD_MAX), 32'hffff_ffff));
    repeat (6) send_item(OP_STEP, '0);
  endtask

  task automatic test_random_lines();
    int counted, cap, steps, sel, tx, ty;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: program_regs(8'd255, 8'd1);
        1: program_regs(8'd1, 8'd255);
        2: program_regs(8'd0, 8'd0);
        default: program_regs(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(1, 12)),
                              ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(1, 8)));
      endcase
      src_idle_pct  = (ph == 4) ? 0 : 34;
      sink_idle_pct = (ph == 4) ? 0 : 34;
      counted = 0;
      while (counted < 140) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          // stray step: counts only if a line is still running
          if (drawing) counted++;
          send_item(OP_STEP, line_word(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                       COORD_BITS'($urandom), COORD_BITS'($urandom),
                                       $urandom));
        end else begin
          sx = COORD_BITS'($urandom_range(COORD_MAX));
          sy = COORD_BITS'($urandom_range(COORD_MAX));
          if (sel < 25) begin
            ex = COORD_BITS'($urandom_range(COORD_MAX));
            ey = COORD_BITS'($urandom_range(COORD_MAX));
          end else begin
            tx = int'(sx) + int'($urandom_range(90)) - 15;
            ty = int'(sy) + int'($urandom_range(90)) - 15;
            ex = (tx < 0) ? '0 : (tx > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                                  : COORD_BITS'(tx);
            ey = (ty < 0) ? '0 : (ty > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                                  : COORD_BITS'(ty);
          end
          send_item(OP_LOAD, line_word(sx, sy, ex, ey, $urandom));
          counted++;
          // most lines run to the end, a few are cut short by the next load
          cap = (sel < 90) ? 60 : $urandom_range(5);
          steps = 0;
          while (drawing && steps < cap) begin
            send_item(OP_STEP, line_word(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                         COORD_BITS'($urandom), COORD_BITS'($urandom),
                                         $urandom));
            steps++;
            counted++;
          end
        end
      end
    end
    src_idle_pct  = 34;
    sink_idle_pct = 34;
  endtask

  task automatic test_output_backpressure();
    drain();
    program_regs(8'd4, 8'd1);
    sink_hold_req = 1'b1;
    send_item(OP_LOAD, line_word(12'd0, 12'd0, COORD_BITS'(COORD_MAX), 12'd100,
                                 32'h55aa_33cc));
    repeat (40) send_item(OP_STEP, '0);
  endtask

  // Receiver: random tready, or a counted hold-off when requested.
  initial begin : sink_ready
    int held;
    held = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          sink_hold_req = 1'b0;
          held = 0;
        end
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Sample between edges: what is seen here is what the next edge takes.
  always @(negedge clk_i) begin : check_blocks
    result_t got, want;
    if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      {got.block_colour, got.block_height, got.block_width, got.block_y, got.block_x} =
        m_axis_tdata_o[OUT_DATA_BITS-1:0];
      got.last_block = m_axis_tlast_o;
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected block x", 32'(got.block_x), '0);
      end else begin
        want = pending_blocks.pop_front();
        if (got.block_x !== want.block_x)
          report_mismatch("block_x", 32'(got.block_x), 32'(want.block_x));
        if (got.block_y !== want.block_y)
          report_mismatch("block_y", 32'(got.block_y), 32'(want.block_y));
        if (got.block_width !== want.block_width)
          report_mismatch("block_width", 32'(got.block_width), 32'(want.block_width));
        if (got.block_height !== want.block_height)
          report_mismatch("block_height", 32'(got.block_height), 32'(want.block_height));
        if (got.block_colour !== want.block_colour)
          report_mismatch("block_colour", got.block_colour, want.block_colour);
        if (got.last_block !== want.last_block)
          report_mismatch("last_block", 32'(got.last_block), 32'(want.last_block));
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o === 1'b1) ||
        (m_axis_tvalid_o === 1'b1 && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("block_line_rasterizer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_BLOCK_SIDE;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = OP_LOAD;
    s_axis_tdata_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_line_cases();
    test_clipping_corners();
    test_canvas_overflow();
    test_random_lines();
    test_output_backpressure();

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_blocks.size() == 0)
      $display("block_line_rasterizer regression: pass");
    else
      $display("block_line_rasterizer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/blr_pkg.sv
rtl/blr_in_reg.sv
rtl/blr_stepper.sv
rtl/blr_out_reg.sv
rtl/block_line_rasterizer.sv
test/tb_block_line_rasterizer.sv
